>>> rtl/ckef_pkg.sv
// Shared types, constants and helper functions for the color key edge fill block.
`timescale 1ns / 1ps
`default_nettype none
package ckef_pkg;

  // Frame geometry limits and field widths.
  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WREG_W       = 10;
  localparam int HREG_W       = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  // Line buffer memory: four row slots of MAX_WIDTH pixels each.
  localparam int ROW_SLOTS    = 4;
  localparam int SLOT_W       = $clog2(ROW_SLOTS);
  localparam int RAM_DEPTH    = ROW_SLOTS * MAX_WIDTH;
  localparam int ADDR_W       = $clog2(RAM_DEPTH);
  localparam int PIX_W        = 32;
  localparam int CH_W         = 8;

  // Neighbor accumulation and division.
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int DIV_STEP_W   = $clog2(SUM_W);
  localparam int SQRT2_FRAC   = 20;
  localparam int SQRT2_W      = 21;
  localparam int PROD_W       = CH_W + SQRT2_W;
  localparam logic [SQRT2_W-1:0] SQRT2_Q20 = 21'd1482910;
  localparam int NB_STEP_W    = 4;
  localparam logic [NB_STEP_W-1:0] NB_READS     = 4'd8;
  localparam logic [NB_STEP_W-1:0] NB_LAST_STEP = 4'd9;

  // Request kinds carried on the input tuser.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Key color.
  localparam logic [CH_W-1:0] KEY_RED   = 8'd0;
  localparam logic [CH_W-1:0] KEY_GREEN = 8'd0;
  localparam logic [CH_W-1:0] KEY_BLUE  = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CENTER,
    ST_NEIGH,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef logic [2:0][SUM_W-1:0] sum_vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic dy_neg;
    logic dy_pos;
    logic dx_neg;
    logic dx_pos;
  } nb_dir_t;

  // Neighbor order: upper row left to right, then left, right, then lower row.
  function automatic nb_dir_t nb_dir(input logic [2:0] idx);
    nb_dir_t d;
    d = '0;
    case (idx)
      3'd0: begin d.dy_neg = 1'b1; d.dx_neg = 1'b1; end
      3'd1: begin d.dy_neg = 1'b1; end
      3'd2: begin d.dy_neg = 1'b1; d.dx_pos = 1'b1; end
      3'd3: begin d.dx_neg = 1'b1; end
      3'd4: begin d.dx_pos = 1'b1; end
      3'd5: begin d.dy_pos = 1'b1; d.dx_neg = 1'b1; end
      3'd6: begin d.dy_pos = 1'b1; end
      3'd7: begin d.dy_pos = 1'b1; d.dx_pos = 1'b1; end
      default: d = '0;
    endcase
    return d;
  endfunction

  // Alpha does not take part in the key test.
  function automatic logic is_key(input logic [PIX_W-1:0] px);
    return (px[7:0] == KEY_RED) && (px[15:8] == KEY_GREEN) && (px[23:16] == KEY_BLUE);
  endfunction

endpackage
`default_nettype wire

>>> rtl/ckef_ram.sv
// Line buffer memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ckef_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ckef_pkg::ADDR_W-1:0] waddr,
  input  wire logic [ckef_pkg::PIX_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [ckef_pkg::ADDR_W-1:0] raddr,
  output logic      [ckef_pkg::PIX_W-1:0]  rdata
);

  logic [ckef_pkg::PIX_W-1:0] mem [0:ckef_pkg::RAM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/ckef_div.sv
// Restoring divider for three channel sums by the neighbor count, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ckef_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire ckef_pkg::sum_vec_t         dividend,
  input  wire logic [ckef_pkg::CNT_W-1:0] divisor,
  output ckef_pkg::sum_vec_t              quotient,
  output ckef_pkg::div_stat_t             stat
);

  logic                                busy;
  logic                                done;
  logic [ckef_pkg::DIV_STEP_W-1:0]     cnt;
  logic [ckef_pkg::CNT_W-1:0]          dvs;
  ckef_pkg::sum_vec_t                  work;
  ckef_pkg::sum_vec_t                  work_next;
  logic [2:0][2:0]                     rem;
  logic [2:0][2:0]                     rem_next;

  // The remainder stays below the divisor (at most 8), so three bits hold it.
  always_comb begin
    logic [ckef_pkg::CNT_W-1:0] tmp;
    logic                       ge;
    tmp       = '0;
    ge        = 1'b0;
    work_next = work;
    rem_next  = rem;
    for (int ch = 0; ch < 3; ch++) begin
      tmp = {rem[ch], work[ch][ckef_pkg::SUM_W-1]};
      ge  = (tmp >= dvs);
      rem_next[ch]  = ge ? 3'(tmp - dvs) : tmp[2:0];
      work_next[ch] = {work[ch][ckef_pkg::SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ckef_pkg::DIV_STEP_W'(ckef_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

>>> rtl/color_key_edge_fill.sv
// Top level: raster sequencer, line buffer access, neighbor accumulation and output register.
// A result leaves once its lower right neighbor is stored; a keyed pixel first takes one
// memory read per neighbor and then, if any neighbor counts, waits on the bit-serial divider.
// Input is taken only in the idle state, so no new item is accepted before the last is done.
// Reset: positions, state and handshakes clear at once; the line buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module color_key_edge_fill (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [31:0]                     s_axis_tdata,  // red, green, blue, alpha
  input  wire logic                            s_axis_tuser,  // req_type
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [31:0]                     m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [ckef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ckef_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = ckef_pkg::COL_W;
  localparam int ROW_W = ckef_pkg::ROW_W;

  ckef_pkg::state_t state, state_next;

  logic [ckef_pkg::WREG_W-1:0] w_eff;
  logic [ckef_pkg::HREG_W-1:0] h_eff;
  logic [ckef_pkg::WREG_W-1:0] w_m1;
  logic [ckef_pkg::HREG_W-1:0] h_m1;

  // Input write position and release position, each with row slot and frame parity.
  logic [COL_W-1:0]            in_col, rel_col;
  logic [ROW_W-1:0]            in_row, rel_row;
  logic [ckef_pkg::SLOT_W-1:0] in_slot, rel_slot;
  logic                        in_frame, rel_frame;
  logic in_last_col, in_last_row, rel_last_col, rel_last_row;

  logic s_accept, pix_we, out_free, out_load, div_start;
  logic same_frame, empty, ahead, ready;
  logic [ckef_pkg::WREG_W-1:0] nx;
  logic [ckef_pkg::HREG_W-1:0] ny;

  logic                          rd_en;
  logic [ckef_pkg::ADDR_W-1:0]   rd_addr;
  logic [ckef_pkg::PIX_W-1:0]    rd_data;

  logic [ckef_pkg::NB_STEP_W-1:0] step;
  ckef_pkg::nb_dir_t              dir;
  logic                           nb_ok, nb_diag;
  logic [ckef_pkg::SLOT_W-1:0]    nb_slot;
  logic [COL_W-1:0]               nb_col;

  logic rp_live, rp_ok, rp_diag;
  logic s1_live, s1_use, s1_diag;
  logic [2:0][ckef_pkg::PROD_W-1:0] s1_prod;
  logic [2:0][ckef_pkg::CH_W-1:0]   s1_raw;
  ckef_pkg::sum_vec_t               sums;
  logic [ckef_pkg::CNT_W-1:0]       count;

  ckef_pkg::sum_vec_t   quot;
  ckef_pkg::div_stat_t  div_stat;
  logic [ckef_pkg::PIX_W-1:0] res;
  logic [ckef_pkg::PIX_W-1:0] fill_px;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign pix_we   = s_accept && (s_axis_tuser == ckef_pkg::REQ_PIXEL);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign w_m1 = w_eff - 1'b1;
  assign h_m1 = h_eff - 1'b1;
  assign in_last_col  = ({1'b0, in_col}  == w_m1);
  assign in_last_row  = ({1'b0, in_row}  == h_m1);
  assign rel_last_col = ({1'b0, rel_col} == w_m1);
  assign rel_last_row = ({1'b0, rel_row} == h_m1);

  // A pixel is ready once its lower right neighbor (clamped to the frame) has been stored.
  // Anything left from the previous frame is always ready.
  assign nx = rel_last_col ? {1'b0, rel_col} : {1'b0, rel_col} + 1'b1;
  assign ny = rel_last_row ? {1'b0, rel_row} : {1'b0, rel_row} + 1'b1;
  assign same_frame = (rel_frame == in_frame);
  assign empty = same_frame && (rel_col == in_col) && (rel_row == in_row);
  assign ahead = (ny < {1'b0, in_row}) || ((ny == {1'b0, in_row}) && (nx < {1'b0, in_col}));
  assign ready = !same_frame || (!empty && ahead);

  // Neighbor addressing; the row slot steps with the row, so rows above and below are
  // the slots on either side of the release slot.
  assign dir     = ckef_pkg::nb_dir(step[2:0]);
  assign nb_ok   = !(dir.dy_neg && (rel_row == '0)) && !(dir.dy_pos && rel_last_row) &&
                   !(dir.dx_neg && (rel_col == '0)) && !(dir.dx_pos && rel_last_col);
  assign nb_diag = (dir.dy_neg || dir.dy_pos) && (dir.dx_neg || dir.dx_pos);
  assign nb_slot = dir.dy_neg ? rel_slot - 1'b1 : (dir.dy_pos ? rel_slot + 1'b1 : rel_slot);
  assign nb_col  = dir.dx_neg ? rel_col - 1'b1 : (dir.dx_pos ? rel_col + 1'b1 : rel_col);

  assign rd_addr = (state == ckef_pkg::ST_NEIGH) ? {nb_slot, nb_col} : {rel_slot, rel_col};

  ckef_ram u_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr ({in_slot, in_col}),
    .wdata (s_axis_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ckef_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums),
    .divisor  (count),
    .quotient (quot),
    .stat     (div_stat)
  );

  // A fill color equal to the key color is dropped to transparent black.
  always_comb begin
    fill_px = {8'h00, quot[2][7:0], quot[1][7:0], quot[0][7:0]};
    if (ckef_pkg::is_key(fill_px)) begin
      fill_px = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ckef_pkg::ST_IDLE:      if (s_accept) state_next = ckef_pkg::ST_CHECK;
      ckef_pkg::ST_CHECK:     state_next = ready ? ckef_pkg::ST_CENTER : ckef_pkg::ST_IDLE;
      ckef_pkg::ST_CENTER: begin
        state_next = ckef_pkg::is_key(rd_data) ? ckef_pkg::ST_NEIGH : ckef_pkg::ST_EMIT;
      end
      ckef_pkg::ST_NEIGH: begin
        if (step == ckef_pkg::NB_LAST_STEP) state_next = ckef_pkg::ST_DIV_START;
      end
      ckef_pkg::ST_DIV_START: begin
        state_next = (count == '0) ? ckef_pkg::ST_EMIT : ckef_pkg::ST_DIV_WAIT;
      end
      ckef_pkg::ST_DIV_WAIT:  if (div_stat.done) state_next = ckef_pkg::ST_EMIT;
      ckef_pkg::ST_EMIT:      if (out_free) state_next = ckef_pkg::ST_IDLE;
      default:                state_next = ckef_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      ckef_pkg::ST_IDLE:      s_axis_tready = 1'b1;
      ckef_pkg::ST_CHECK:     rd_en = ready;
      ckef_pkg::ST_NEIGH:     rd_en = (step < ckef_pkg::NB_READS);
      ckef_pkg::ST_DIV_START: div_start = (count != '0);
      ckef_pkg::ST_EMIT:      out_load = out_free;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Configuration, positions and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ckef_pkg::ST_IDLE;
      w_eff     <= 10'd16;
      h_eff     <= 13'd16;
      in_col    <= '0;
      in_row    <= '0;
      in_slot   <= '0;
      in_frame  <= 1'b0;
      rel_col   <= '0;
      rel_row   <= '0;
      rel_slot  <= '0;
      rel_frame <= 1'b0;
    end else if (cfg_we) begin
      // A register write restarts the frame.
      state     <= ckef_pkg::ST_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      in_slot   <= '0;
      in_frame  <= 1'b0;
      rel_col   <= '0;
      rel_row   <= '0;
      rel_slot  <= '0;
      rel_frame <= 1'b0;
      if (cfg_index == ckef_pkg::REG_WIDTH) begin
        if (cfg_data[ckef_pkg::WREG_W-1:0] == '0) begin
          w_eff <= 10'd1;
        end else if (cfg_data[ckef_pkg::WREG_W-1:0] > 10'(ckef_pkg::MAX_WIDTH)) begin
          w_eff <= 10'(ckef_pkg::MAX_WIDTH);
        end else begin
          w_eff <= cfg_data[ckef_pkg::WREG_W-1:0];
        end
      end else begin
        if (cfg_data == '0) begin
          h_eff <= 13'd1;
        end else if (cfg_data > 13'(ckef_pkg::MAX_HEIGHT)) begin
          h_eff <= 13'(ckef_pkg::MAX_HEIGHT);
        end else begin
          h_eff <= cfg_data;
        end
      end
    end else begin
      state <= state_next;
      if (pix_we) begin
        if (in_last_col) begin
          in_col  <= '0;
          in_slot <= in_slot + 1'b1;
          if (in_last_row) begin
            in_row   <= '0;
            in_frame <= !in_frame;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (out_load) begin
        if (rel_last_col) begin
          rel_col  <= '0;
          rel_slot <= rel_slot + 1'b1;
          if (rel_last_row) begin
            rel_row   <= '0;
            rel_frame <= !rel_frame;
          end else begin
            rel_row <= rel_row + 1'b1;
          end
        end else begin
          rel_col <= rel_col + 1'b1;
        end
      end
    end
  end

  // Neighbor sweep control: a read issued at one step is scaled in the next cycle and
  // summed in the one after, so the sweep runs on past the last read until it is summed.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp_live <= 1'b0;
      s1_live <= 1'b0;
      step    <= '0;
    end else begin
      rp_live <= (state == ckef_pkg::ST_NEIGH) && (step < ckef_pkg::NB_READS);
      s1_live <= rp_live;
      if (state == ckef_pkg::ST_CENTER) begin
        step <= '0;
      end else if (state == ckef_pkg::ST_NEIGH) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rp_ok   <= nb_ok;
    rp_diag <= nb_diag;
    s1_use  <= rp_ok && !ckef_pkg::is_key(rd_data);
    s1_diag <= rp_diag;
    for (int ch = 0; ch < 3; ch++) begin
      s1_raw[ch]  <= rd_data[ch*ckef_pkg::CH_W +: ckef_pkg::CH_W];
      s1_prod[ch] <= ckef_pkg::PROD_W'(rd_data[ch*ckef_pkg::CH_W +: ckef_pkg::CH_W]) *
                     ckef_pkg::PROD_W'(ckef_pkg::SQRT2_Q20);
    end
  end

  // Diagonal neighbors add floor(c * sqrt2) from the fixed-point product.
  always_ff @(posedge clk) begin
    if (state == ckef_pkg::ST_CENTER) begin
      sums  <= '0;
      count <= '0;
    end else if (s1_live && s1_use) begin
      count <= count + 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        sums[ch] <= sums[ch] + (s1_diag ?
          ckef_pkg::SUM_W'(s1_prod[ch][ckef_pkg::PROD_W-1:ckef_pkg::SQRT2_FRAC]) :
          ckef_pkg::SUM_W'(s1_raw[ch]));
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ckef_pkg::ST_CENTER:    res <= rd_data;
      ckef_pkg::ST_DIV_START: res <= '0;
      ckef_pkg::ST_DIV_WAIT:  res <= fill_px;
      default:                res <= res;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res;
      m_axis_tlast <= rel_last_col && rel_last_row;
    end
  end

  // The release position never passes the write position within a frame.
  a_release_behind_write: assert property (@(posedge clk) disable iff (rst)
    (rel_frame == in_frame) |->
      ((rel_row < in_row) || ((rel_row == in_row) && (rel_col <= in_col))))
    else $error("release position ahead of write position");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (count != '0))
    else $error("division started with no neighbors");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_stat.busy)
    else $error("input accepted while divider busy");

  a_emit_leaves: assert property (@(posedge clk) disable iff (rst || cfg_we)
    out_load |=> (m_axis_tvalid && (state == ckef_pkg::ST_IDLE)))
    else $error("output load did not return to idle");

endmodule
`default_nettype wire
